// ----- src/assert_macros.svh -----
// Concurrent assertion helpers, clocked on aclk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define U8_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define U8_IMPLIES(lbl, ante, cons, msg) \
    `U8_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- src/u8u16_pkg.sv -----
`default_nettype none

package u8u16_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [15:0] SURR_HI     = 16'hD800;
    localparam logic [15:0] SURR_LO     = 16'hDC00;
    localparam logic [20:0] SURR_FIRST  = 21'h00D800;
    localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] PLANE1      = 21'h010000;
    localparam logic [20:0] MIN_TWO     = 21'h000080;
    localparam logic [20:0] MIN_THREE   = 21'h000800;
    localparam logic [7:0]  LEAD2_MIN   = 8'hC2;
    localparam logic [7:0]  LEAD2_MAX   = 8'hDF;
    localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
    localparam logic [7:0]  LEAD3_MAX   = 8'hEF;
    localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
    localparam logic [7:0]  LEAD4_MAX   = 8'hF4;
    localparam logic [5:0]  CONT_MASK   = 6'h3F;
    localparam logic [20:0] CP_LF       = 21'h00000A;
    localparam logic [20:0] CP_CR       = 21'h00000D;
    localparam logic [15:0] UNIT_CR     = 16'h000D;
    localparam logic [15:0] UNIT_TERM   = 16'h0000;

    typedef struct packed {
        logic [2:0]  repl_cnt;
        logic        cr_prefix;
        logic [1:0]  cp_units;
        logic [15:0] unit_a;
        logic [15:0] unit_b;
        logic        term;
    } cmd_t;

    function automatic logic [2:0] cmd_units(input cmd_t c);
        cmd_units = c.repl_cnt + {2'b00, c.cr_prefix} + {1'b0, c.cp_units}
                  + {2'b00, c.term};
    endfunction

endpackage

`default_nettype wire

// ----- src/u8u16_front.sv -----
`default_nettype none

module u8u16_front (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  wire  [7:0]         s_tdata,   // [7:0] text_byte
    input  wire                s_tlast,   // is_end
    output logic               cmd_valid,
    input  wire                cmd_ready,
    output u8u16_pkg::cmd_t    cmd
);
    import u8u16_pkg::*;

    logic [20:0] pv_reg, pv_next;
    logic [1:0]  need_reg, need_next;
    logic [1:0]  got_reg, got_next;
    logic        pcr_reg, pcr_next;

    logic [7:0]  b;
    logic        lead_ascii, lead_bad;
    logic [1:0]  lead_need;
    logic [20:0] lead_pv;
    logic [20:0] cont_pv;
    logic [1:0]  got_inc;
    logic [20:0] lowest;
    logic        cp_bad;
    logic        accept;

    logic [2:0]  repl;
    logic        has_cp;
    logic [20:0] cp;
    logic        term;
    logic        pcr_eff;
    logic        pair;
    logic [20:0] off;

    assign b       = s_tdata;
    assign accept  = s_tvalid && s_tready;
    assign s_tready = cmd_ready;

    always_comb begin
        lead_ascii = (b[7] == 1'b0);
        lead_need  = 2'd0;
        lead_pv    = 21'd0;
        lead_bad   = 1'b0;
        if (lead_ascii) begin
            lead_bad = 1'b0;
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            lead_need = 2'd1;
            lead_pv   = {16'd0, b[4:0]};
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            lead_need = 2'd2;
            lead_pv   = {17'd0, b[3:0]};
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            lead_need = 2'd3;
            lead_pv   = {18'd0, b[2:0]};
        end else begin
            lead_bad = 1'b1;
        end
    end

    assign cont_pv = {pv_reg[14:0], b[5:0] & CONT_MASK};
    assign got_inc = got_reg + 2'd1;

    always_comb begin
        unique case (need_reg)
            2'd1:    lowest = MIN_TWO;
            2'd2:    lowest = MIN_THREE;
            default: lowest = PLANE1;
        endcase
    end

    assign cp_bad = (cont_pv < lowest) || (cont_pv > CP_MAX)
                 || (cont_pv >= SURR_FIRST && cont_pv <= SURR_LAST);

    always_comb begin
        repl      = 3'd0;
        has_cp    = 1'b0;
        cp        = 21'd0;
        term      = 1'b0;
        pv_next   = pv_reg;
        need_next = need_reg;
        got_next  = got_reg;
        priority if (s_tlast) begin
            repl      = (need_reg != 2'd0) ? ({1'b0, got_reg} + 3'd1) : 3'd0;
            term      = 1'b1;
            pv_next   = 21'd0;
            need_next = 2'd0;
            got_next  = 2'd0;
        end else if (need_reg == 2'd0) begin
            has_cp    = lead_ascii;
            cp        = {13'd0, b};
            repl      = {2'b00, lead_bad};
            need_next = lead_need;
            pv_next   = lead_pv;
            got_next  = 2'd0;
        end else if (b[7:6] == 2'b10) begin
            if (got_inc == need_reg) begin
                pv_next   = 21'd0;
                need_next = 2'd0;
                got_next  = 2'd0;
                if (cp_bad) begin
                    repl = {1'b0, need_reg} + 3'd1;
                end else begin
                    has_cp = 1'b1;
                    cp     = cont_pv;
                end
            end else begin
                pv_next  = cont_pv;
                got_next = got_inc;
            end
        end else begin
            // broken sequence: flush, then decode this byte as a new lead
            repl      = {1'b0, got_reg} + 3'd1 + {2'b00, lead_bad};
            has_cp    = lead_ascii;
            cp        = {13'd0, b};
            need_next = lead_need;
            pv_next   = lead_pv;
            got_next  = 2'd0;
        end
    end

    assign pcr_eff = (repl == 3'd0) && pcr_reg;
    assign pair    = (cp >= PLANE1);
    assign off     = cp - PLANE1;

    always_comb begin
        if (s_tlast) begin
            pcr_next = 1'b0;
        end else if (has_cp) begin
            pcr_next = (cp == CP_CR);
        end else if (repl != 3'd0) begin
            pcr_next = 1'b0;
        end else begin
            pcr_next = pcr_reg;
        end
    end

    always_comb begin
        cmd.repl_cnt  = repl;
        cmd.cr_prefix = has_cp && (cp == CP_LF) && !pcr_eff;
        cmd.cp_units  = has_cp ? (pair ? 2'd2 : 2'd1) : 2'd0;
        cmd.unit_a    = pair ? (SURR_HI | {6'd0, off[19:10]}) : cp[15:0];
        cmd.unit_b    = SURR_LO | {6'd0, off[9:0]};
        cmd.term      = term;
    end

    assign cmd_valid = s_tvalid && (cmd_units(cmd) != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg   <= 21'd0;
            need_reg <= 2'd0;
            got_reg  <= 2'd0;
            pcr_reg  <= 1'b0;
        end else if (accept) begin
            pv_reg   <= pv_next;
            need_reg <= need_next;
            got_reg  <= got_next;
            pcr_reg  <= pcr_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/u8u16_queue.sv -----
`default_nettype none

module u8u16_queue (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push_valid,
    output logic               push_ready,
    input  u8u16_pkg::cmd_t    push_data,
    output logic               pop_valid,
    input  wire                pop_ready,
    output u8u16_pkg::cmd_t    pop_data
);
    import u8u16_pkg::*;

    cmd_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QUEUE_CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/u8u16_back.sv -----
`default_nettype none

module u8u16_back (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cmd_valid,
    output logic               cmd_ready,
    input  u8u16_pkg::cmd_t    cmd,
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [15:0]        m_tdata,   // [15:0] code_unit
    output logic               m_tuser,   // is_terminator
    output logic               m_tlast    // last
);
    import u8u16_pkg::*;

    logic [2:0]  step_reg, step_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;

    logic        load;
    logic [2:0]  units;
    logic        last_step;
    logic [2:0]  j;
    logic [2:0]  j2;
    logic [15:0] unit;
    logic        unit_term;

    assign load      = !m_tvalid_reg || m_tready;
    assign units     = cmd_units(cmd);
    assign last_step = (step_reg == units - 3'd1);
    assign cmd_ready = load && last_step;

    assign j  = step_reg - cmd.repl_cnt;
    assign j2 = j - {2'b00, cmd.cr_prefix};

    always_comb begin
        unit_term = 1'b0;
        if (step_reg < cmd.repl_cnt) begin
            unit = REPLACEMENT;
        end else if (cmd.cr_prefix && j == 3'd0) begin
            unit = UNIT_CR;
        end else if (j2 < {1'b0, cmd.cp_units}) begin
            unit = (j2 == 3'd0) ? cmd.unit_a : cmd.unit_b;
        end else begin
            unit      = UNIT_TERM;
            unit_term = 1'b1;
        end
    end

    always_comb begin
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (load) begin
            m_tvalid_next = cmd_valid;
            if (cmd_valid) begin
                m_tdata_next = unit;
                m_tuser_next = unit_term;
                m_tlast_next = last_step;
                step_next    = last_step ? 3'd0 : step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ----- src/utf8_to_utf16le_crlf.sv -----
`default_nettype none

`include "assert_macros.svh"

// UTF-8 to UTF-16 transcoder with LF to CR LF expansion. One byte enters on
// s_ each cycle while the queue has room; the decoder updates its sequence
// state in that same cycle and posts the units the byte completes to a
// four-entry queue. The output side sends one 16-bit code unit per cycle from
// a registered stage while m_tready is high, so bytes that give one unit or
// none stream at one per cycle, and a byte that gives more (up to five, on
// malformed input, surrogate pairs, CR insertion or end of text) holds the
// output for each unit while the queue keeps taking input until it fills.
// Each unit is queued, then registered. An item with tlast set ends the text:
// pending bytes come out as FFFD, a zero unit with tuser set follows, and the
// decoder starts fresh. m_tlast marks the last unit caused by one input item.
module utf8_to_utf16le_crlf (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] text_byte
    input  wire         s_tlast,   // is_end
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tuser,   // is_terminator
    output logic        m_tlast    // last
);
    import u8u16_pkg::*;

    logic  push_valid, push_ready;
    cmd_t  push_data;
    logic  pop_valid, pop_ready;
    cmd_t  pop_data;

    u8u16_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd_valid (push_valid),
        .cmd_ready (push_ready),
        .cmd       (push_data)
    );

    u8u16_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    u8u16_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    `U8_IMPLIES(a_term_last, m_tvalid && m_tuser, m_tlast && m_tdata == UNIT_TERM, "bad terminator")
    `U8_IMPLIES(a_head_nonempty, pop_valid, cmd_units(pop_data) != 3'd0, "empty queue entry")
    `U8_IMPLIES(a_rest_queued, m_tvalid && !m_tlast, pop_valid, "item lost from queue")

endmodule

`default_nettype wire
